// File: hdl/rama_pkg.sv
// Shared types and codes for the ring mutual-exclusion node
`timescale 1ns / 1ps

package rama_pkg;

    // input operation codes
    localparam logic [1:0] OP_MSG     = 2'd0;
    localparam logic [1:0] OP_WANT    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam int NODE_W = 3;
    localparam int TIME_W = 32;

    // command kinds decided by the front end
    typedef enum logic [2:0] {
        K_MSG_REQ,
        K_MSG_REPLY,
        K_WANT,
        K_RELEASE,
        K_NOP
    } t_kind;

    // one classified beat between front and back end
    typedef struct packed {
        t_kind               kind;
        logic                side;
        logic [NODE_W-1:0]   node;
        logic [TIME_W-1:0]   msg_time;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic                send_valid;
        logic                out_side;
        logic [NODE_W-1:0]   out_node;
        logic [TIME_W-1:0]   out_time;
        logic                out_is_reply;
        logic                granted;
        logic                defer_overflow;
        logic                last;
    } t_result;

endpackage

// File: hdl/rama_front.sv
// Front end: takes input beats and decodes them into commands
`timescale 1ns / 1ps

module rama_front
    import rama_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_operation,
    input  logic                i_side,
    input  logic [NODE_W-1:0]   i_msg_node,
    input  logic [TIME_W-1:0]   i_msg_time,
    input  logic                i_msg_is_reply,
    output t_cmd                o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready
);

    logic  r_valid;
    t_cmd  r_cmd;
    t_kind kind;
    logic  accept;

    // decode operation into a command kind
    always_comb begin
        case (i_operation)
            OP_MSG:     kind = i_msg_is_reply ? K_MSG_REPLY : K_MSG_REQ;
            OP_WANT:    kind = K_WANT;
            OP_RELEASE: kind = K_RELEASE;
            default:    kind = K_NOP;
        endcase
    end

    assign full        = r_valid && !i_cmd_ready;
    assign accept      = push && !full;
    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

    // holding register in front of the command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd.kind     <= kind;
            r_cmd.side     <= i_side;
            r_cmd.node     <= i_msg_node;
            r_cmd.msg_time <= i_msg_time;
        end
    end

endmodule

// File: hdl/rama_cmd_fifo.sv
// Two-entry command queue between front and back end
`timescale 1ns / 1ps

module rama_cmd_fifo
    import rama_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_wr_cmd,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    output t_cmd o_rd_cmd,
    output logic o_rd_valid,
    input  logic i_rd_ready
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_wr;
    logic       do_rd;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_valid && o_wr_ready;
    assign do_rd      = o_rd_valid && i_rd_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

// File: hdl/rama_back.sv
// Back end: protocol state, deferred-request store and result register
`timescale 1ns / 1ps

module rama_back
    import rama_pkg::*;
#(
    parameter int DEFER_DEPTH = 8,
    parameter int RING_SIZE   = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [NODE_W-1:0]   i_node_id,
    input  t_cmd                i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    output t_result             o_result,
    output logic                empty,
    input  logic                pop
);

    localparam int IW = $clog2(DEFER_DEPTH);
    localparam int CW = $clog2(DEFER_DEPTH + 1);
    localparam logic [4:0] RING = 5'(RING_SIZE);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WANT2,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_THINK,
        PH_WANT,
        PH_EAT
    } t_phase;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [TIME_W-1:0] req_time;
    } t_entry;

    t_state            r_state,    n_state;
    t_phase            r_phase,    n_phase;
    logic [TIME_W-1:0] r_clock,    n_clock;
    logic [TIME_W-1:0] r_req_time, n_req_time;
    logic [1:0]        r_marks,    n_marks;
    logic [CW-1:0]     r_count,    n_count;
    logic [IW-1:0]     r_idx,      n_idx;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,      n_out;

    t_entry            r_mem [DEFER_DEPTH];
    t_entry            r_rd_data;
    logic              mem_we;

    logic              out_free;
    logic [TIME_W-1:0] cmax;
    logic [TIME_W-1:0] bumped;
    logic              lower;
    logic              store_full;
    logic [1:0]        marks_set;
    logic [4:0]        right;
    logic              drain_last;

    function automatic t_result mk_result(
        input logic              valid,
        input logic              side,
        input logic [NODE_W-1:0] node,
        input logic [TIME_W-1:0] tval,
        input logic              reply,
        input logic              grant,
        input logic              ovf,
        input logic              last
    );
        t_result r;
        r.send_valid     = valid;
        r.out_side       = valid ? side : 1'b0;
        r.out_node       = valid ? node : '0;
        r.out_time       = valid ? tval : '0;
        r.out_is_reply   = valid ? reply : 1'b0;
        r.granted        = grant;
        r.defer_overflow = ovf;
        r.last           = last;
        return r;
    endfunction

    // right neighbor: (node_id + 1) mod ring size by repeated subtract
    always_comb begin
        right = 5'(i_node_id) + 5'd1;
        for (int k = 0; k < 3; k++) begin
            if (right >= RING) begin
                right = right - RING;
            end
        end
    end

    // clock bump and request ordering
    assign cmax       = (r_clock > i_cmd.msg_time) ? r_clock : i_cmd.msg_time;
    assign bumped     = (cmax == {TIME_W{1'b1}}) ? cmax : cmax + TIME_W'(1);
    assign lower      = (i_cmd.msg_time < r_req_time) ||
                        ((i_cmd.msg_time == r_req_time) && (i_cmd.node < i_node_id));
    assign store_full = (r_count == CW'(DEFER_DEPTH));
    assign marks_set  = r_marks | (i_cmd.side ? 2'b10 : 2'b01);
    assign drain_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign out_free   = !r_out_valid || pop;

    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign empty       = !r_out_valid;
    assign o_result    = r_out;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clock     = r_clock;
        n_req_time  = r_req_time;
        n_marks     = r_marks;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !pop;
        n_out       = r_out;
        mem_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    n_out_valid = 1'b1;
                    n_out = mk_result(1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    case (i_cmd.kind)
                        K_MSG_REQ: begin
                            n_clock = bumped;
                            if (r_phase == PH_THINK || (r_phase == PH_WANT && lower)) begin
                                n_out = mk_result(1'b1, i_cmd.side, i_node_id,
                                                  i_cmd.msg_time, 1'b1, 1'b0, 1'b0, 1'b1);
                            end else if (r_phase == PH_WANT || r_phase == PH_EAT) begin
                                if (store_full) begin
                                    n_out.defer_overflow = 1'b1;
                                end else begin
                                    mem_we  = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                        K_MSG_REPLY: begin
                            n_clock = bumped;
                            if (r_phase == PH_WANT && i_cmd.msg_time == r_req_time) begin
                                n_marks = marks_set;
                                if (marks_set == 2'b11) begin
                                    n_out.granted = 1'b1;
                                    n_phase = PH_EAT;
                                end
                            end
                        end
                        K_WANT: begin
                            if (r_phase == PH_THINK) begin
                                n_req_time = r_clock;
                                n_marks    = 2'b00;
                                n_phase    = PH_WANT;
                                n_state    = S_WANT2;
                                n_out = mk_result(1'b1, 1'b0, i_node_id, r_clock,
                                                  1'b0, 1'b0, 1'b0, 1'b0);
                            end
                        end
                        K_RELEASE: begin
                            if (r_phase == PH_EAT) begin
                                if (r_count == '0) begin
                                    n_marks = 2'b00;
                                    n_phase = PH_THINK;
                                end else begin
                                    n_out_valid = r_out_valid && !pop;
                                    n_out       = r_out;
                                    n_idx       = '0;
                                    n_state     = S_DRAIN_RD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WANT2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = mk_result(1'b1, 1'b1, i_node_id, r_req_time,
                                      1'b0, 1'b0, 1'b0, 1'b1);
                    n_state = S_IDLE;
                end
            end
            S_DRAIN_RD: begin
                n_state = S_DRAIN_OUT;
            end
            S_DRAIN_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = mk_result(1'b1, (5'(r_rd_data.node) == right), i_node_id,
                                      r_rd_data.req_time, 1'b1, 1'b0, 1'b0, drain_last);
                    if (drain_last) begin
                        n_count = '0;
                        n_marks = 2'b00;
                        n_phase = PH_THINK;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_DRAIN_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_THINK;
            r_clock     <= '0;
            r_req_time  <= '0;
            r_marks     <= 2'b00;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clock     <= n_clock;
            r_req_time  <= n_req_time;
            r_marks     <= n_marks;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // deferred-request store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[IW-1:0]] <= '{node: i_cmd.node, req_time: i_cmd.msg_time};
        end
        r_rd_data <= r_mem[r_idx];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEFER_DEPTH))
        else $error("deferred count above store depth");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN_RD || r_state == S_DRAIN_OUT) |-> (r_count != '0))
        else $error("draining an empty store");

    a_grant_eats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.granted) |-> (r_phase == PH_EAT))
        else $error("grant beat without eating phase");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.defer_overflow) |-> store_full)
        else $error("overflow flagged with room in store");

    a_want_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WANT2) |-> (r_phase == PH_WANT && r_out_valid))
        else $error("second request beat out of sequence");
`endif

endmodule

// File: hdl/ricart_agrawala_mutex_node.sv
// Top level of one ring mutual-exclusion node
`timescale 1ns / 1ps

// One node of a ring that shares a critical section by timestamped requests
// and replies with a Lamport clock. Items enter through push/full and results
// leave through empty/pop, one result beat per pop; the last beat of each item
// has o_last set. A received message, a want or a stray/ignored item is handled
// in the back end from S_IDLE (a want yields two beats, the second from S_WANT2);
// a release with N deferred requests yields no beat at its start and then N reply
// beats, each read in S_DRAIN_RD and sent in S_DRAIN_OUT, as the read of the deferred-request store is registered.
// Items are decoded in the front end and queued in a two-entry command queue,
// so input keeps flowing while a result waits. node_id is written through
// i_cfg_wr_en/i_cfg_wr_data; the user must do so only while idle (not enforced).

module ricart_agrawala_mutex_node
    import rama_pkg::*;
#(
    parameter int DEFER_DEPTH = 8,
    parameter int RING_SIZE   = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [NODE_W-1:0]   i_cfg_wr_data,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_operation,
    input  logic                i_side,
    input  logic [NODE_W-1:0]   i_msg_node,
    input  logic [TIME_W-1:0]   i_msg_time,
    input  logic                i_msg_is_reply,
    output logic                empty,
    input  logic                pop,
    output logic                o_send_valid,
    output logic                o_out_side,
    output logic [NODE_W-1:0]   o_out_node,
    output logic [TIME_W-1:0]   o_out_time,
    output logic                o_out_is_reply,
    output logic                o_granted,
    output logic                o_defer_overflow,
    output logic                o_last
);

    logic [NODE_W-1:0] r_node_id;
    t_cmd              front_cmd;
    logic              front_valid;
    logic              front_ready;
    t_cmd              back_cmd;
    logic              back_valid;
    logic              back_ready;
    t_result           result;

    // node id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id <= '0;
        end else if (i_cfg_wr_en) begin
            r_node_id <= i_cfg_wr_data;
        end
    end

    // front end
    rama_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_side         (i_side),
        .i_msg_node     (i_msg_node),
        .i_msg_time     (i_msg_time),
        .i_msg_is_reply (i_msg_is_reply),
        .o_cmd          (front_cmd),
        .o_cmd_valid    (front_valid),
        .i_cmd_ready    (front_ready)
    );

    // command queue
    rama_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cmd   (front_cmd),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .o_rd_cmd   (back_cmd),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready)
    );

    // back end
    rama_back #(
        .DEFER_DEPTH (DEFER_DEPTH),
        .RING_SIZE   (RING_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_node_id   (r_node_id),
        .i_cmd       (back_cmd),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .o_result    (result),
        .empty       (empty),
        .pop         (pop)
    );

    // result fields
    assign o_send_valid     = result.send_valid;
    assign o_out_side       = result.out_side;
    assign o_out_node       = result.out_node;
    assign o_out_time       = result.out_time;
    assign o_out_is_reply   = result.out_is_reply;
    assign o_granted        = result.granted;
    assign o_defer_overflow = result.defer_overflow;
    assign o_last           = result.last;

endmodule
